// ===== rtl/core/bfd_pkg.sv =====
// Shared types, widths and tables for the box filter downscaler.
// No dependencies; every other file of the block but bfd_ram refers to this package.
`default_nettype none

package bfd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int SUM_BITS = 24;
	localparam int MAX_WIDTH = 8192;
	localparam int WIDTH_BITS = 14;
	localparam int LINE_BITS = 13;
	localparam int MAX_SCALE = 16;
	localparam int SCALE_BITS = 5;
	localparam int PHASE_BITS = 4;
	localparam int MAX_OUT_WIDTH = 2048;
	localparam int COL_BITS = 11;
	localparam int BCOL_BITS = 12;
	localparam int SPAN_BITS = BCOL_BITS + SCALE_BITS + 1;
	localparam int ROW_BITS = 13;
	localparam int ROW_LIMIT = 8191;
	localparam int AREA_BITS = 9;
	localparam int RECIP_BITS = 32;
	localparam int PROD_BITS = SUM_BITS + RECIP_BITS;
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_TDATA_BITS = 3 * SAMPLE_BITS;
	localparam int OUT_TDATA_BITS = 3 * SAMPLE_BITS + COL_BITS + ROW_BITS;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = 14;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_BITS-1:0] sum_t;
	typedef logic [WIDTH_BITS-1:0] width_t;
	typedef logic [LINE_BITS-1:0] line_t;
	typedef logic [SCALE_BITS-1:0] scale_t;
	typedef logic [PHASE_BITS-1:0] phase_t;
	typedef logic [COL_BITS-1:0] col_t;
	typedef logic [BCOL_BITS-1:0] bcol_t;
	typedef logic [SPAN_BITS-1:0] span_t;
	typedef logic [ROW_BITS-1:0] row_t;
	typedef logic [AREA_BITS-1:0] area_t;
	typedef logic [RECIP_BITS-1:0] recip_t;
	typedef logic [PROD_BITS-1:0] prod_t;
	typedef logic [QPTR_BITS-1:0] qptr_t;
	typedef logic [QCNT_BITS-1:0] qcnt_t;
	typedef logic [QCNT_BITS:0] flight_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t CFG_IMAGE_WIDTH = cfg_index_t'(0);
	localparam cfg_index_t CFG_SCALE = cfg_index_t'(1);
	localparam width_t WIDTH_RESET = width_t'(8192);
	localparam scale_t SCALE_RESET = scale_t'(8);

	typedef struct packed {
		sample_t blue;
		sample_t green;
		sample_t red;
	} pixel_t;

	typedef struct packed {
		sum_t blue;
		sum_t green;
		sum_t red;
	} sums_t;

	typedef struct packed {
		row_t row;
		col_t column;
		logic end_of_row;
	} tag_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic emit;
		pixel_t pixel;
		tag_t tag;
	} acc_req_t;

	typedef struct packed {
		area_t area;
		recip_t recip;
	} div_cfg_t;

	typedef struct packed {
		pixel_t avg;
		tag_t tag;
	} result_t;

	// floor(2^32 / scale^2), scale one held at all ones; the quotient comes out
	// at most one low and is fixed up by the remainder check
	function automatic recip_t recip_of(phase_t scale_m1);
		recip_t r;
		unique case (scale_m1)
			4'd0:  r = 32'hFFFF_FFFF;
			4'd1:  r = 32'd1073741824;
			4'd2:  r = 32'd477218588;
			4'd3:  r = 32'd268435456;
			4'd4:  r = 32'd171798691;
			4'd5:  r = 32'd119304647;
			4'd6:  r = 32'd87652393;
			4'd7:  r = 32'd67108864;
			4'd8:  r = 32'd53024287;
			4'd9:  r = 32'd42949672;
			4'd10: r = 32'd35495597;
			4'd11: r = 32'd29826161;
			4'd12: r = 32'd25414007;
			4'd13: r = 32'd21913098;
			4'd14: r = 32'd19088743;
			4'd15: r = 32'd16777216;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents. No dependencies.
`default_nettype none

module bfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bfd_front.sv =====
// Configuration registers and raster position counters of the downscaler.
// Turns each accepted pixel into an accumulator request. Uses bfd_pkg.
`default_nettype none

module bfd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  bfd_pkg::cfg_index_t cfg_index,
	input  logic [bfd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                take,
	input  logic                start_of_frame,
	input  bfd_pkg::pixel_t     pixel,
	output bfd_pkg::acc_req_t   req,
	output bfd_pkg::div_cfg_t   div_cfg
);

	bfd_pkg::width_t image_width_q;
	bfd_pkg::scale_t scale_q;
	bfd_pkg::line_t  line_pos_q;
	bfd_pkg::phase_t col_in_blk_q;
	bfd_pkg::phase_t row_in_blk_q;
	bfd_pkg::bcol_t  blk_col_q;
	bfd_pkg::row_t   blk_row_q;

	bfd_pkg::width_t width_eff;
	bfd_pkg::scale_t scale_eff;
	bfd_pkg::phase_t scale_m1;
	bfd_pkg::line_t  cur_lp;
	bfd_pkg::phase_t cur_cib;
	bfd_pkg::phase_t cur_rib;
	bfd_pkg::bcol_t  cur_bc;
	bfd_pkg::row_t   cur_br;
	bfd_pkg::span_t  span1;
	bfd_pkg::span_t  span2;
	logic            in_range;
	logic            last_col;
	logic            col_end;
	logic            row_end;
	logic            line_end;

	always_comb begin
		priority if (image_width_q == '0) begin
			width_eff = bfd_pkg::width_t'(1);
		end else if (image_width_q > bfd_pkg::width_t'(bfd_pkg::MAX_WIDTH)) begin
			width_eff = bfd_pkg::width_t'(bfd_pkg::MAX_WIDTH);
		end else begin
			width_eff = image_width_q;
		end
		priority if (scale_q == '0) begin
			scale_eff = bfd_pkg::scale_t'(1);
		end else if (scale_q > bfd_pkg::scale_t'(bfd_pkg::MAX_SCALE)) begin
			scale_eff = bfd_pkg::scale_t'(bfd_pkg::MAX_SCALE);
		end else begin
			scale_eff = scale_q;
		end
	end

	assign scale_m1 = bfd_pkg::phase_t'(scale_eff - bfd_pkg::scale_t'(1));

	assign cur_lp  = start_of_frame ? '0 : line_pos_q;
	assign cur_cib = start_of_frame ? '0 : col_in_blk_q;
	assign cur_rib = start_of_frame ? '0 : row_in_blk_q;
	assign cur_bc  = start_of_frame ? '0 : blk_col_q;
	assign cur_br  = start_of_frame ? '0 : blk_row_q;

	// column c is inside the output width when (c+1)*scale <= width
	assign span1 = (bfd_pkg::span_t'(cur_bc) + bfd_pkg::span_t'(1)) * bfd_pkg::span_t'(scale_eff);
	assign span2 = span1 + bfd_pkg::span_t'(scale_eff);
	assign in_range = (cur_bc < bfd_pkg::bcol_t'(bfd_pkg::MAX_OUT_WIDTH))
		&& (span1 <= bfd_pkg::span_t'(width_eff));
	assign last_col = (cur_bc == bfd_pkg::bcol_t'(bfd_pkg::MAX_OUT_WIDTH - 1))
		|| (span2 > bfd_pkg::span_t'(width_eff));
	assign col_end  = cur_cib >= scale_m1;
	assign row_end  = cur_rib >= scale_m1;
	assign line_end = (bfd_pkg::width_t'(cur_lp) + bfd_pkg::width_t'(1)) >= width_eff;

	always_comb begin
		req.valid          = take && in_range;
		req.first          = (cur_rib == '0) && (cur_cib == '0);
		req.emit           = in_range && row_end && col_end;
		req.pixel          = pixel;
		req.tag.row        = cur_br;
		req.tag.column     = cur_bc[bfd_pkg::COL_BITS-1:0];
		req.tag.end_of_row = last_col;
		div_cfg.area  = bfd_pkg::area_t'(bfd_pkg::area_t'(scale_eff) * bfd_pkg::area_t'(scale_eff));
		div_cfg.recip = bfd_pkg::recip_of(scale_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= bfd_pkg::WIDTH_RESET;
			scale_q       <= bfd_pkg::SCALE_RESET;
			line_pos_q    <= '0;
			col_in_blk_q  <= '0;
			row_in_blk_q  <= '0;
			blk_col_q     <= '0;
			blk_row_q     <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					bfd_pkg::CFG_IMAGE_WIDTH: image_width_q <= cfg_wdata;
					bfd_pkg::CFG_SCALE:       scale_q <= cfg_wdata[bfd_pkg::SCALE_BITS-1:0];
				endcase
			end
			if (take) begin
				if (line_end) begin
					line_pos_q   <= '0;
					col_in_blk_q <= '0;
					blk_col_q    <= '0;
					if (row_end) begin
						row_in_blk_q <= '0;
						if (cur_br < bfd_pkg::row_t'(bfd_pkg::ROW_LIMIT)) begin
							blk_row_q <= cur_br + bfd_pkg::row_t'(1);
						end else begin
							blk_row_q <= cur_br;
						end
					end else begin
						row_in_blk_q <= cur_rib + bfd_pkg::phase_t'(1);
						blk_row_q    <= cur_br;
					end
				end else begin
					line_pos_q   <= cur_lp + bfd_pkg::line_t'(1);
					row_in_blk_q <= cur_rib;
					blk_row_q    <= cur_br;
					if (col_end) begin
						col_in_blk_q <= '0;
						if (cur_bc < bfd_pkg::bcol_t'(bfd_pkg::MAX_OUT_WIDTH)) begin
							blk_col_q <= cur_bc + bfd_pkg::bcol_t'(1);
						end else begin
							blk_col_q <= cur_bc;
						end
					end else begin
						col_in_blk_q <= cur_cib + bfd_pkg::phase_t'(1);
						blk_col_q    <= cur_bc;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bfd_accum.sv =====
// Column accumulator memory with read-modify-write and write-to-read forwarding.
// Depends on bfd_pkg and bfd_ram; feeds finished block sums to the divider.
`default_nettype none

module bfd_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  bfd_pkg::acc_req_t req,
	output logic              emit_s1,
	output logic              valid_s2,
	output bfd_pkg::sums_t    sums_s2,
	output bfd_pkg::tag_t     tag_s2
);

	logic              valid_s1;
	bfd_pkg::acc_req_t req_s1;
	bfd_pkg::sums_t    rdata;
	bfd_pkg::sums_t    old_sums;
	bfd_pkg::sums_t    new_sums;
	logic              fwd_valid_q;
	bfd_pkg::col_t     fwd_addr_q;
	bfd_pkg::sums_t    fwd_sums_q;

	bfd_ram #(
		.WIDTH ($bits(bfd_pkg::sums_t)),
		.DEPTH (bfd_pkg::MAX_OUT_WIDTH)
	) u_sum_ram (
		.clk   (clk),
		.wen   (valid_s1),
		.waddr (req_s1.tag.column),
		.wdata (new_sums),
		.ren   (req.valid),
		.raddr (req.tag.column),
		.rdata (rdata)
	);

	// write of the previous word landed in the same cycle as this read
	assign old_sums = (fwd_valid_q && (fwd_addr_q == req_s1.tag.column)) ? fwd_sums_q : rdata;

	always_comb begin
		if (req_s1.first) begin
			new_sums.red   = bfd_pkg::sum_t'(req_s1.pixel.red);
			new_sums.green = bfd_pkg::sum_t'(req_s1.pixel.green);
			new_sums.blue  = bfd_pkg::sum_t'(req_s1.pixel.blue);
		end else begin
			new_sums.red   = old_sums.red + bfd_pkg::sum_t'(req_s1.pixel.red);
			new_sums.green = old_sums.green + bfd_pkg::sum_t'(req_s1.pixel.green);
			new_sums.blue  = old_sums.blue + bfd_pkg::sum_t'(req_s1.pixel.blue);
		end
	end

	assign emit_s1 = valid_s1 && req_s1.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			valid_s1    <= req.valid;
			fwd_valid_q <= valid_s1;
			valid_s2    <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		req_s1     <= req;
		fwd_addr_q <= req_s1.tag.column;
		fwd_sums_q <= new_sums;
		sums_s2    <= new_sums;
		tag_s2     <= req_s1.tag;
	end

endmodule

`default_nettype wire

// ===== rtl/core/bfd_divide.sv =====
// Pipelined division of block sums by scale squared: reciprocal multiply,
// back-multiply, one-step remainder correction and saturation. Uses bfd_pkg.
`default_nettype none

module bfd_divide (
	input  logic              clk,
	input  logic              arst_n,
	input  bfd_pkg::div_cfg_t div_cfg,
	input  logic              valid_s2,
	input  bfd_pkg::sums_t    sums_s2,
	input  bfd_pkg::tag_t     tag_s2,
	output logic              valid_s3,
	output logic              valid_s4,
	output bfd_pkg::result_t  result
);

	bfd_pkg::prod_t prod_r;
	bfd_pkg::prod_t prod_g;
	bfd_pkg::prod_t prod_b;
	bfd_pkg::sums_t n_s3;
	bfd_pkg::sums_t q0_s3;
	bfd_pkg::tag_t  tag_s3;
	bfd_pkg::sums_t n_s4;
	bfd_pkg::sums_t q0_s4;
	bfd_pkg::sums_t qa_s4;
	bfd_pkg::tag_t  tag_s4;

	function automatic bfd_pkg::sample_t fix_mean(bfd_pkg::sum_t n, bfd_pkg::sum_t q0,
		bfd_pkg::sum_t qa, bfd_pkg::area_t area);
		bfd_pkg::sum_t                rem;
		logic [bfd_pkg::SUM_BITS:0]   q;
		bfd_pkg::sample_t             m;
		rem = n - qa;
		q = {1'b0, q0} + {{bfd_pkg::SUM_BITS{1'b0}}, (rem >= bfd_pkg::sum_t'(area))};
		if (q > {{(bfd_pkg::SUM_BITS + 1 - bfd_pkg::SAMPLE_BITS){1'b0}},
			{bfd_pkg::SAMPLE_BITS{1'b1}}}) begin
			m = '1;
		end else begin
			m = q[bfd_pkg::SAMPLE_BITS-1:0];
		end
		return m;
	endfunction

	assign prod_r = bfd_pkg::prod_t'(sums_s2.red) * bfd_pkg::prod_t'(div_cfg.recip);
	assign prod_g = bfd_pkg::prod_t'(sums_s2.green) * bfd_pkg::prod_t'(div_cfg.recip);
	assign prod_b = bfd_pkg::prod_t'(sums_s2.blue) * bfd_pkg::prod_t'(div_cfg.recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		n_s3        <= sums_s2;
		q0_s3.red   <= prod_r[bfd_pkg::PROD_BITS-1:bfd_pkg::RECIP_BITS];
		q0_s3.green <= prod_g[bfd_pkg::PROD_BITS-1:bfd_pkg::RECIP_BITS];
		q0_s3.blue  <= prod_b[bfd_pkg::PROD_BITS-1:bfd_pkg::RECIP_BITS];
		tag_s3      <= tag_s2;
		n_s4        <= n_s3;
		q0_s4       <= q0_s3;
		qa_s4.red   <= q0_s3.red * bfd_pkg::sum_t'(div_cfg.area);
		qa_s4.green <= q0_s3.green * bfd_pkg::sum_t'(div_cfg.area);
		qa_s4.blue  <= q0_s3.blue * bfd_pkg::sum_t'(div_cfg.area);
		tag_s4      <= tag_s3;
	end

	always_comb begin
		result.avg.red   = fix_mean(n_s4.red, q0_s4.red, qa_s4.red, div_cfg.area);
		result.avg.green = fix_mean(n_s4.green, q0_s4.green, qa_s4.green, div_cfg.area);
		result.avg.blue  = fix_mean(n_s4.blue, q0_s4.blue, qa_s4.blue, div_cfg.area);
		result.tag       = tag_s4;
	end

endmodule

`default_nettype wire

// ===== rtl/core/bfd_outq.sv =====
// Output queue of finished result words ahead of the master-side stream.
// Depends on bfd_pkg for the word type and depth.
`default_nettype none

module bfd_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bfd_pkg::result_t push_data,
	input  logic             pop_ready,
	output logic             out_valid,
	output bfd_pkg::result_t out_data,
	output bfd_pkg::qcnt_t   count
);

	bfd_pkg::result_t entries_q [bfd_pkg::QUEUE_DEPTH];
	bfd_pkg::qptr_t   wr_ptr_q;
	bfd_pkg::qptr_t   rd_ptr_q;
	bfd_pkg::qcnt_t   count_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign out_data  = entries_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = out_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bfd_pkg::qptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bfd_pkg::qptr_t'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bfd_pkg::qcnt_t'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bfd_pkg::qcnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/box_filter_downscaler.sv =====
// Box filter downscaler: averages scale x scale blocks of a raster RGB stream.
// Takes one pixel per clock while not stalled; each pixel does one read-modify-write
// of the 2048 x 72-bit column accumulator memory, with forwarding so that
// back-to-back pixels of the same block column need no stall. A finished block
// leaves through a reciprocal-multiply divider and an 8-word output queue; the
// slave side stalls only when that queue and the results still in the pipeline
// would fill it. No clearing pass is needed after reset: the first pixel of each
// block band overwrites its column sum.
// Depends on bfd_pkg, bfd_front, bfd_accum, bfd_divide, bfd_outq and bfd_ram.
`default_nettype none

module box_filter_downscaler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  bfd_pkg::cfg_index_t cfg_index,
	input  logic [bfd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// red, green, blue
	input  logic [bfd_pkg::IN_TDATA_BITS-1:0] s_tdata,
	// start_of_frame
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// avg_red, avg_green, avg_blue, out_column, out_row
	output logic [bfd_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	output logic                m_tlast
);

	localparam int SB = bfd_pkg::SAMPLE_BITS;

	bfd_pkg::pixel_t   in_pixel;
	bfd_pkg::acc_req_t req;
	bfd_pkg::div_cfg_t div_cfg;
	bfd_pkg::sums_t    sums_s2;
	bfd_pkg::tag_t     tag_s2;
	bfd_pkg::result_t  result;
	bfd_pkg::result_t  out_word;
	bfd_pkg::qcnt_t    q_count;
	bfd_pkg::flight_t  in_use;
	logic              take;
	logic              emit_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;

	assign in_pixel.red   = s_tdata[SB-1:0];
	assign in_pixel.green = s_tdata[2*SB-1:SB];
	assign in_pixel.blue  = s_tdata[3*SB-1:2*SB];

	assign take = s_tvalid && s_tready;

	// queue slots already promised to results on their way
	assign in_use = bfd_pkg::flight_t'(q_count) + bfd_pkg::flight_t'(emit_s1)
		+ bfd_pkg::flight_t'(valid_s2) + bfd_pkg::flight_t'(valid_s3)
		+ bfd_pkg::flight_t'(valid_s4);
	assign s_tready = in_use < bfd_pkg::flight_t'(bfd_pkg::QUEUE_DEPTH);

	bfd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.take           (take),
		.start_of_frame (s_tuser),
		.pixel          (in_pixel),
		.req            (req),
		.div_cfg        (div_cfg)
	);

	bfd_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.emit_s1  (emit_s1),
		.valid_s2 (valid_s2),
		.sums_s2  (sums_s2),
		.tag_s2   (tag_s2)
	);

	bfd_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.div_cfg  (div_cfg),
		.valid_s2 (valid_s2),
		.sums_s2  (sums_s2),
		.tag_s2   (tag_s2),
		.valid_s3 (valid_s3),
		.valid_s4 (valid_s4),
		.result   (result)
	);

	bfd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s4),
		.push_data (result),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_word),
		.count     (q_count)
	);

	assign m_tdata = {out_word.tag.row, out_word.tag.column,
		out_word.avg.blue, out_word.avg.green, out_word.avg.red};
	assign m_tlast = out_word.tag.end_of_row;

endmodule

`default_nettype wire

// ===== rtl/core/bfd_checker.sv =====
// Port-level checks for box_filter_downscaler, attached by the bind below.
// Depends on bfd_pkg for port widths.
`default_nettype none

module bfd_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [bfd_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input logic m_tlast
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// input backpressure only comes from words waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output word pending");

	// an output word after an empty queue comes from a pixel word taken earlier at the input
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
		else $error("output word without matching input word");

endmodule

bind box_filter_downscaler bfd_checker u_bfd_checker (.*);

`default_nettype wire

// ===== tb/bfd_mean_checker.sv =====
// Scoreboard for the box filter downscaler: follows register writes and accepted
// pixel words, predicts every block mean and checks result words in order.
// Depends on bfd_pkg.
module bfd_mean_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  bfd_pkg::cfg_index_t                 cfg_index,
	input  logic [bfd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	// red, green, blue
	input  logic [bfd_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	// start_of_frame
	input  logic                                s_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// avg_red, avg_green, avg_blue, out_column, out_row
	input  logic [bfd_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
	input  logic                                m_tlast,
	output int                                  pending,
	output int                                  errors
);
	import bfd_pkg::*;

	typedef struct packed {
		row_t   row;
		col_t   column;
		pixel_t avg;
	} out_word_t;

	typedef struct packed {
		logic      end_of_row;
		out_word_t word;
	} mean_word_t;

	longint unsigned sum_r [MAX_OUT_WIDTH];
	longint unsigned sum_g [MAX_OUT_WIDTH];
	longint unsigned sum_b [MAX_OUT_WIDTH];
	int unsigned line_pos, col_in_blk, row_in_blk, blk_col, blk_row;
	width_t width_reg;
	scale_t scale_reg;
	mean_word_t expected_means [$];

	// truncated mean, clipped to the largest sample when stale sums pile up
	function automatic sample_t mean_of(longint unsigned sum, int unsigned area);
		longint unsigned q;
		q = sum / area;
		return (q > 64'hFFFF) ? 16'hFFFF : sample_t'(q);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned w, s, outw, c;
		pixel_t px;
		mean_word_t m, want;
		out_word_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_OUT_WIDTH; i++) begin
				sum_r[i] = 0;
				sum_g[i] = 0;
				sum_b[i] = 0;
			end
			line_pos = 0;
			col_in_blk = 0;
			row_in_blk = 0;
			blk_col = 0;
			blk_row = 0;
			width_reg = WIDTH_RESET;
			scale_reg = SCALE_RESET;
			expected_means.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == CFG_IMAGE_WIDTH)
					width_reg = width_t'(cfg_wdata);
				else if (cfg_index == CFG_SCALE)
					scale_reg = scale_t'(cfg_wdata);
			end

			if (s_tvalid && s_tready) begin
				px = pixel_t'(s_tdata);
				w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
				s = (scale_reg == 0) ? 1 : (scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg;
				outw = w / s;
				if (outw > MAX_OUT_WIDTH)
					outw = MAX_OUT_WIDTH;
				if (s_tuser) begin
					line_pos = 0;
					col_in_blk = 0;
					row_in_blk = 0;
					blk_col = 0;
					blk_row = 0;
				end
				if (blk_col < outw) begin
					c = blk_col;
					if (row_in_blk == 0 && col_in_blk == 0) begin
						sum_r[c] = px.red;
						sum_g[c] = px.green;
						sum_b[c] = px.blue;
					end else begin
						sum_r[c] += px.red;
						sum_g[c] += px.green;
						sum_b[c] += px.blue;
					end
					if (row_in_blk >= s - 1 && col_in_blk >= s - 1) begin
						m.word.avg.red = mean_of(sum_r[c], s * s);
						m.word.avg.green = mean_of(sum_g[c], s * s);
						m.word.avg.blue = mean_of(sum_b[c], s * s);
						m.word.column = col_t'(c);
						m.word.row = row_t'(blk_row);
						m.end_of_row = (c == outw - 1);
						expected_means.push_back(m);
					end
				end
				if (line_pos + 1 >= w) begin
					line_pos = 0;
					col_in_blk = 0;
					blk_col = 0;
					if (row_in_blk >= s - 1) begin
						row_in_blk = 0;
						if (blk_row < ROW_LIMIT)
							blk_row++;
					end else begin
						row_in_blk++;
					end
				end else begin
					line_pos++;
					if (col_in_blk >= s - 1) begin
						col_in_blk = 0;
						if (blk_col < MAX_OUT_WIDTH)
							blk_col++;
					end else begin
						col_in_blk++;
					end
				end
			end

			if (m_tvalid && m_tready) begin
				got = out_word_t'(m_tdata);
				if (expected_means.size() == 0) begin
					$display("%0t: unexpected word r=%h g=%h b=%h col=%0d row=%0d last=%b",
						$time, got.avg.red, got.avg.green, got.avg.blue, got.column,
						got.row, m_tlast);
					errors <= errors + 1;
				end else begin
					want = expected_means.pop_front();
					if (want.word !== got || want.end_of_row !== m_tlast) begin
						$display("%0t: mismatch expected r=%h g=%h b=%h col=%0d row=%0d last=%b",
							$time, want.word.avg.red, want.word.avg.green,
							want.word.avg.blue, want.word.column, want.word.row,
							want.end_of_row);
						$display("%0t:          actual   r=%h g=%h b=%h col=%0d row=%0d last=%b",
							$time, got.avg.red, got.avg.green, got.avg.blue, got.column,
							got.row, m_tlast);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_means.size();
		end
	end

endmodule

// ===== tb/tb_box_filter_downscaler.sv =====
// Testbench top for box_filter_downscaler: resets once, writes the registers
// between phases and streams pixel words with random pacing on both sides.
// Depends on bfd_pkg, box_filter_downscaler and bfd_mean_checker.
module tb_box_filter_downscaler;
	import bfd_pkg::*;

	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int RANDOM_ITEMS = 1000;

	logic clk, arst_n, cfg_wen;
	cfg_index_t cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	logic s_tvalid, s_tready, s_tuser;
	logic [IN_TDATA_BITS-1:0] s_tdata;
	logic m_tvalid, m_tlast;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	int pending, errors;
	int cycle_count = 0;
	int ready_left = 0;
	bit dense = 0;
	sample_t pattern [8] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
		16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE};

	box_filter_downscaler dut (.*);
	bfd_mean_checker mean_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: open stretches, short stalls and the odd long one
	always @(posedge clk) begin : rx_pace
		int unsigned r;
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				m_tready <= 1'b1;
				ready_left <= $urandom_range(30, 200);
			end else if (r < 60) begin
				m_tready <= 1'b1;
				ready_left <= $urandom_range(0, 6);
			end else if (r < 95) begin
				m_tready <= 1'b0;
				ready_left <= $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b0;
				ready_left <= $urandom_range(10, 50);
			end
		end
	end

	function automatic int unsigned idle_gap();
		int unsigned r;
		if (dense)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t rand_sample();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return sample_t'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic send_pixel(input logic sof, input sample_t r, input sample_t g,
			input sample_t b);
		int unsigned gap;
		gap = idle_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= sof;
		s_tdata <= {b, g, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_pattern(input int k, input logic sof);
		send_pixel(sof, pattern[k % 8], pattern[(k + 3) % 8], pattern[(k + 5) % 8]);
	endtask

	// hold off until every predicted word is out, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_config(input int unsigned width, input int unsigned scale_val);
		settle();
		cfg_wen <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_wdata <= CFG_DATA_BITS'(width);
		@(posedge clk);
		cfg_index <= CFG_SCALE;
		cfg_wdata <= CFG_DATA_BITS'(scale_val);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned s_wr, w_wr, s_eff, w_eff, rows, n, budget, r;
		int random_sent;
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// corner samples; right-edge column dropped; scale zero
		write_config(4, 2);
		for (int k = 0; k < 8; k++)
			send_pattern(k, k == 0);
		write_config(5, 2);
		for (int k = 0; k < 10; k++)
			send_pattern(k + 2, k == 0);
		write_config(3, 0);
		for (int k = 0; k < 3; k++)
			send_pattern(k + 5, k == 0);

		// scale and width changed inside a frame; the mixed sum clips
		write_config(8, 4);
		for (int k = 0; k < 30; k++)
			send_pattern(k, k == 0);
		write_config(8, 1);
		for (int k = 0; k < 10; k++)
			send_pattern(k, 1'b0);
		write_config(3, 1);
		for (int k = 0; k < 6; k++)
			send_pattern(k, 1'b0);

		// scale above the maximum
		write_config(17, 31);
		for (int k = 0; k < 272; k++)
			send_pixel(k == 0, rand_sample(), rand_sample(), rand_sample());

		// width zero, one pixel per band
		write_config(0, 1);
		for (int k = 0; k < 40; k++)
			send_pixel(k == 0, rand_sample(), rand_sample(), rand_sample());

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				s_wr = 0;
			else if (r < 10)
				s_wr = $urandom_range(17, 31);
			else if (r < 20)
				s_wr = $urandom_range(9, 16);
			else
				s_wr = $urandom_range(1, 8);
			s_eff = (s_wr == 0) ? 1 : (s_wr > MAX_SCALE) ? MAX_SCALE : s_wr;
			r = $urandom_range(0, 99);
			if (r < 4)
				w_wr = 0;
			else if (r < 8)
				w_wr = $urandom_range(1, s_eff);
			else if (r < 12)
				w_wr = $urandom_range(MAX_WIDTH, 16383);
			else
				w_wr = s_eff * $urandom_range(1, s_eff > 8 ? 2 : 6)
					+ $urandom_range(0, s_eff - 1);
			w_eff = (w_wr == 0) ? 1 : (w_wr > MAX_WIDTH) ? MAX_WIDTH : w_wr;
			budget = (s_eff > 8) ? 400 : $urandom_range(60, 200);
			write_config(w_wr, s_wr);
			dense = ($urandom_range(0, 3) == 0);
			while (budget > 0) begin
				rows = s_eff * $urandom_range(1, s_eff > 8 ? 1 : 3);
				if ($urandom_range(0, 4) == 0)
					rows += $urandom_range(0, s_eff - 1);
				n = rows * w_eff;
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(1, n);
				for (int k = 0; k < n && budget > 0; k++) begin
					send_pixel(k == 0 || $urandom_range(0, 199) == 0,
						rand_sample(), rand_sample(), rand_sample());
					budget--;
					random_sent++;
				end
			end
		end
		dense = 0;

		settle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
